>>> sv/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg - shared types and constants of the dwindle rectangle splitter
// widths, register indexes, queue sizing and the beat layouts of the block
// ----------------------------------------------------------------------------
package dwr_pkg;

	localparam int COORD_BITS     = 16;
	localparam int HANDLE_BITS    = 8;
	localparam int SPAN_BITS      = COORD_BITS - 1;
	localparam int GAP_BITS       = 10;
	localparam int SCREEN_BITS    = 4;
	localparam int WS_BITS        = 5;
	localparam int CALC_BITS      = COORD_BITS + 2;

	localparam int IN_FIELD_BITS  = HANDLE_BITS + SCREEN_BITS + WS_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = HANDLE_BITS + 2 * COORD_BITS + 2 * SPAN_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = COORD_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X      = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y      = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_USABLE_WIDTH  = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_USABLE_HEIGHT = CFG_INDEX_BITS'(3);
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_SIZE      = CFG_INDEX_BITS'(4);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_SEL    = CFG_INDEX_BITS'(5);
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORKSPACE_SEL = CFG_INDEX_BITS'(6);

	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;
	localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

	localparam logic signed [CALC_BITS-1:0] CALC_ONE  = CALC_BITS'(1);
	localparam logic signed [CALC_BITS-1:0] CALC_TWO  = CALC_BITS'(2);
	localparam logic [SPAN_BITS-1:0]        SPAN_ONE  = SPAN_BITS'(1);
	localparam logic [COORD_BITS-1:0]       COORD_ONE = COORD_BITS'(1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] usable_width;
		logic signed [COORD_BITS-1:0] usable_height;
		logic [GAP_BITS-1:0]          gap_size;
		logic [SCREEN_BITS-1:0]       screen_select;
		logic [WS_BITS-1:0]           workspace_select;
	} dwr_cfg_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic                   match;
		logic                   last;
	} dwr_item_t;

	typedef struct packed {
		logic      valid;
		dwr_item_t item;
	} dwr_head_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0]       window_handle;
		logic signed [COORD_BITS-1:0] area_x;
		logic signed [COORD_BITS-1:0] area_y;
		logic [SPAN_BITS-1:0]         area_width;
		logic [SPAN_BITS-1:0]         area_height;
		logic                         pass_done;
		logic                         no_window;
	} dwr_result_t;

endpackage

>>> sv/dwr_front.sv
// ----------------------------------------------------------------------------
// dwr_front - entry intake and classification
// accepts window entries, marks those on the selected screen and workspace,
// and holds them in a short queue for the layout engine
// ----------------------------------------------------------------------------
module dwr_front import dwr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dwr_cfg_t                cfg,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
	input  logic                    s_axis_tlast,
	input  logic                    pop,
	output dwr_head_t               head
);

	dwr_item_t                 queue_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      push;
	dwr_item_t                 new_item;
	logic [SCREEN_BITS-1:0]    in_screen;
	logic [WS_BITS-1:0]        in_workspace;

	assign in_screen    = s_axis_tdata[HANDLE_BITS +: SCREEN_BITS];
	assign in_workspace = s_axis_tdata[HANDLE_BITS + SCREEN_BITS +: WS_BITS];

	always_comb begin
		new_item.handle = s_axis_tdata[HANDLE_BITS-1:0];
		new_item.match  = (in_screen == cfg.screen_select) &&
			(in_workspace == cfg.workspace_select);
		new_item.last   = s_axis_tlast;
	end

	assign s_axis_tready = (count_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;

	assign head.valid = (count_q != '0);
	assign head.item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/dwr_back.sv
// ----------------------------------------------------------------------------
// dwr_back - layout engine
// keeps the pending rectangle, splits it for each further matching entry in two
// steps and drives results through an output register
// ----------------------------------------------------------------------------
module dwr_back import dwr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dwr_cfg_t    cfg,
	input  dwr_head_t   head,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output dwr_result_t result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SPLIT = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [1:0]              state_q;
	logic [COORD_BITS-1:0]   pend_x_q;
	logic [COORD_BITS-1:0]   pend_y_q;
	logic [SPAN_BITS-1:0]    pend_w_q;
	logic [SPAN_BITS-1:0]    pend_h_q;
	logic [HANDLE_BITS-1:0]  pend_handle_q;
	logic                    have_pend_q;
	logic                    parity_q;

	logic signed [CALC_BITS-1:0] diff_q;
	logic signed [CALC_BITS-1:0] first_q;
	logic [COORD_BITS-1:0]       pos_gap_q;
	logic [COORD_BITS-1:0]       pos_span_q;
	logic [HANDLE_BITS-1:0]      new_handle_q;
	logic                        last_q;

	logic                        out_valid_q;
	dwr_result_t                 out_q;
	logic                        out_free;
	logic                        emit;
	dwr_result_t                 res;

	// split setup
	logic [SPAN_BITS-1:0]        span_c;
	logic signed [CALC_BITS-1:0] span_ext;
	logic signed [CALC_BITS-1:0] gap_ext;
	logic signed [CALC_BITS-1:0] diff_c;
	logic signed [CALC_BITS-1:0] first_c;
	logic [COORD_BITS-1:0]       pos_c;
	logic [COORD_BITS-1:0]       gap_coord;

	// split finish
	logic signed [CALC_BITS-1:0] other_c;
	logic                        short_c;
	logic signed [CALC_BITS-1:0] first_fin;
	logic [SPAN_BITS-1:0]        other_fin;
	logic [COORD_BITS-1:0]       pos_next;
	logic [SPAN_BITS-1:0]        first_emit;

	// first rectangle
	logic signed [CALC_BITS-1:0] init_w_c;
	logic signed [CALC_BITS-1:0] init_h_c;
	logic [SPAN_BITS-1:0]        init_w;
	logic [SPAN_BITS-1:0]        init_h;

	assign gap_ext   = signed'({{(CALC_BITS - GAP_BITS){1'b0}}, cfg.gap_size});
	assign gap_coord = {{(COORD_BITS - GAP_BITS){1'b0}}, cfg.gap_size};

	assign span_c   = parity_q ? pend_w_q : pend_h_q;
	assign span_ext = signed'({{(CALC_BITS - SPAN_BITS){1'b0}}, span_c});
	assign diff_c   = span_ext - gap_ext;
	assign first_c  = (diff_c >= CALC_TWO) ? (diff_c >>> 1) : (span_ext >>> 1);
	assign pos_c    = parity_q ? pend_x_q : pend_y_q;

	assign other_c    = diff_q - first_q;
	assign short_c    = (other_c < CALC_ONE);
	assign first_fin  = short_c ? (diff_q - CALC_ONE) : first_q;
	assign other_fin  = short_c ? SPAN_ONE : other_c[SPAN_BITS-1:0];
	assign pos_next   = short_c ? pos_span_q : (pos_gap_q + first_q[COORD_BITS-1:0]);
	assign first_emit = (first_fin < CALC_ONE) ? SPAN_ONE : first_fin[SPAN_BITS-1:0];

	assign init_w_c = signed'({{2{cfg.usable_width[COORD_BITS-1]}}, cfg.usable_width})
		- (gap_ext <<< 1);
	assign init_h_c = signed'({{2{cfg.usable_height[COORD_BITS-1]}}, cfg.usable_height})
		- (gap_ext <<< 1);
	assign init_w   = (init_w_c < CALC_ONE) ? SPAN_ONE : init_w_c[SPAN_BITS-1:0];
	assign init_h   = (init_h_c < CALC_ONE) ? SPAN_ONE : init_h_c[SPAN_BITS-1:0];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign result        = out_q;

	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		res  = '0;
		case (state_q)
			ST_IDLE: begin
				pop = head.valid;
			end
			ST_SPLIT: begin
				if (out_free) begin
					emit              = 1'b1;
					res.window_handle = pend_handle_q;
					res.area_x        = signed'(pend_x_q);
					res.area_y        = signed'(pend_y_q);
					res.area_width    = parity_q ? first_emit : pend_w_q;
					res.area_height   = parity_q ? pend_h_q : first_emit;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					emit          = 1'b1;
					res.pass_done = 1'b1;
					if (have_pend_q) begin
						res.window_handle = pend_handle_q;
						res.area_x        = signed'(pend_x_q);
						res.area_y        = signed'(pend_y_q);
						res.area_width    = pend_w_q;
						res.area_height   = pend_h_q;
					end else begin
						res.no_window = 1'b1;
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		if (state_q == ST_IDLE) begin
			diff_q       <= diff_c;
			first_q      <= first_c;
			pos_gap_q    <= pos_c + gap_coord;
			pos_span_q   <= pos_c + {1'b0, span_c} - COORD_ONE;
			new_handle_q <= head.item.handle;
			last_q       <= head.item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			pend_x_q      <= '0;
			pend_y_q      <= '0;
			pend_w_q      <= '0;
			pend_h_q      <= '0;
			pend_handle_q <= '0;
			have_pend_q   <= 1'b0;
			parity_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.item.match && !have_pend_q) begin
							pend_x_q      <= cfg.origin_x + gap_coord;
							pend_y_q      <= cfg.origin_y + gap_coord;
							pend_w_q      <= init_w;
							pend_h_q      <= init_h;
							pend_handle_q <= head.item.handle;
							have_pend_q   <= 1'b1;
							parity_q      <= 1'b1;
							state_q       <= head.item.last ? ST_FINAL : ST_IDLE;
						end else if (head.item.match) begin
							state_q <= ST_SPLIT;
						end else begin
							state_q <= head.item.last ? ST_FINAL : ST_IDLE;
						end
					end
				end
				ST_SPLIT: begin
					if (out_free) begin
						if (parity_q) begin
							pend_x_q <= pos_next;
							pend_w_q <= other_fin;
						end else begin
							pend_y_q <= pos_next;
							pend_h_q <= other_fin;
						end
						pend_handle_q <= new_handle_q;
						parity_q      <= !parity_q;
						state_q       <= last_q ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						have_pend_q <= 1'b0;
						parity_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/dwindle_rectangle_split.sv
// ----------------------------------------------------------------------------
// dwindle_rectangle_split - dwindle tiling layout of a window list
// window entries in, tile rectangles out; register file for the layout area
//
//   channel  | beat content                                   | direction
//   s_axis   | client entry, tlast marks the final entry      | in
//   m_axis   | tile rectangle, tlast ends the pass            | out
//   cfg      | register write, index and data                 | in
//
// an entry that splits the pending tile passes the idle state of the layout engine,
// where the split is set up, and then the split state; other entries pass only the
// idle state; a closing entry goes on to the final state; the split is two-step
// a 4-beat queue separates intake from the engine, an output register from m_axis
// reset clears the registers to their defaults, the queue and the output register
// ----------------------------------------------------------------------------
module dwindle_rectangle_split import dwr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// client_handle, client_screen, client_workspace
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
	input  logic                      s_axis_tlast,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// window_handle, area_x, area_y, area_width, area_height
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
	output logic                      m_axis_tlast,
	// no_window
	output logic                      m_axis_tuser
);

	dwr_cfg_t    cfg_q;
	dwr_head_t   head;
	logic        pop;
	dwr_result_t res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x         <= '0;
			cfg_q.origin_y         <= '0;
			cfg_q.usable_width     <= COORD_BITS'(1);
			cfg_q.usable_height    <= COORD_BITS'(1);
			cfg_q.gap_size         <= '0;
			cfg_q.screen_select    <= '0;
			cfg_q.workspace_select <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ORIGIN_X:      cfg_q.origin_x         <= cfg_data;
				REG_ORIGIN_Y:      cfg_q.origin_y         <= cfg_data;
				REG_USABLE_WIDTH:  cfg_q.usable_width     <= cfg_data;
				REG_USABLE_HEIGHT: cfg_q.usable_height    <= cfg_data;
				REG_GAP_SIZE:      cfg_q.gap_size         <= cfg_data[GAP_BITS-1:0];
				REG_SCREEN_SEL:    cfg_q.screen_select    <= cfg_data[SCREEN_BITS-1:0];
				REG_WORKSPACE_SEL: cfg_q.workspace_select <= cfg_data[WS_BITS-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	dwr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.pop           (pop),
		.head          (head)
	);

	dwr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.result        (res_out)
	);

	assign m_axis_tdata = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
		res_out.area_height, res_out.area_width, res_out.area_y,
		res_out.area_x, res_out.window_handle};
	assign m_axis_tlast = res_out.pass_done;
	assign m_axis_tuser = res_out.no_window;

	a_empty_closes_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("empty result without end of pass");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("empty result carries a rectangle");

	a_tile_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		res_out.area_width != '0 && res_out.area_height != '0)
		else $error("tile with zero size");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue read while empty");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the dwindle rectangle splitter
// drives window entries over s_axis with random gaps, accepts tile beats on
// m_axis with random stalls, and checks every tile against a dwindle layout
// predictor kept in a small scoreboard class; the layout registers are
// rewritten between phases, directed corner cases first, random passes after
// ----------------------------------------------------------------------------
module tb;
	import dwr_pkg::*;

	localparam int LIMIT           = 1000000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PHASES          = 24;
	localparam int ITEMS_PER_PHASE = 73;
	localparam int X_LSB           = HANDLE_BITS;
	localparam int Y_LSB           = X_LSB + COORD_BITS;
	localparam int W_LSB           = Y_LSB + COORD_BITS;
	localparam int H_LSB           = W_LSB + SPAN_BITS;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [SCREEN_BITS-1:0] screen;
		logic [WS_BITS-1:0]     workspace;
		logic                   last;
	} entry_t;

	class tile_scoreboard;
		dwr_result_t             expected_tiles[$];
		int                      errors;
		longint                  org_x, org_y, use_w, use_h, gap;
		logic [SCREEN_BITS-1:0]  scr_sel;
		logic [WS_BITS-1:0]      ws_sel;
		longint                  pend_x, pend_y, pend_w, pend_h;
		logic [HANDLE_BITS-1:0]  pend_handle;
		bit                      have_pend;
		bit                      split_w;

		function new();
			errors = 0;
			org_x = 0;
			org_y = 0;
			use_w = 1;
			use_h = 1;
			gap = 0;
			scr_sel = '0;
			ws_sel = '0;
			pend_x = 0;
			pend_y = 0;
			pend_w = 0;
			pend_h = 0;
			pend_handle = '0;
			have_pend = 0;
			split_w = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_ORIGIN_X:      org_x = longint'($signed(value));
				REG_ORIGIN_Y:      org_y = longint'($signed(value));
				REG_USABLE_WIDTH:  use_w = longint'($signed(value));
				REG_USABLE_HEIGHT: use_h = longint'($signed(value));
				REG_GAP_SIZE:      gap = longint'(value[GAP_BITS-1:0]);
				REG_SCREEN_SEL:    scr_sel = value[SCREEN_BITS-1:0];
				REG_WORKSPACE_SEL: ws_sel = value[WS_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint wrap_coord(longint v);
			logic [COORD_BITS-1:0] low;
			low = v[COORD_BITS-1:0];
			return longint'($signed(low));
		endfunction

		function longint split_span(longint s, longint g, output longint second);
			longint f;
			f = (s - g) / 2;
			if (f < 1)
				f = s / 2;
			second = s - f - g;
			if (second < 1) begin
				second = 1;
				f = s - g - 1;
			end
			return f;
		endfunction

		function void push_tile(logic [HANDLE_BITS-1:0] handle, longint x, longint y,
				longint w, longint h, logic done);
			dwr_result_t t;
			if (w < 1)
				w = 1;
			if (h < 1)
				h = 1;
			t.window_handle = handle;
			t.area_x = x[COORD_BITS-1:0];
			t.area_y = y[COORD_BITS-1:0];
			t.area_width = w[SPAN_BITS-1:0];
			t.area_height = h[SPAN_BITS-1:0];
			t.pass_done = done;
			t.no_window = 1'b0;
			expected_tiles.insert(expected_tiles.size(), t);
		endfunction

		function void note_entry(entry_t e);
			longint f, second, w, h;
			dwr_result_t empty_tile;
			if (e.screen == scr_sel && e.workspace == ws_sel) begin
				if (!have_pend) begin
					w = use_w - 2 * gap;
					h = use_h - 2 * gap;
					if (w < 1)
						w = 1;
					if (h < 1)
						h = 1;
					pend_x = wrap_coord(org_x + gap);
					pend_y = wrap_coord(org_y + gap);
					pend_w = w;
					pend_h = h;
					have_pend = 1;
					split_w = 1;
				end else if (split_w) begin
					f = split_span(pend_w, gap, second);
					push_tile(pend_handle, pend_x, pend_y, f, pend_h, 1'b0);
					pend_x = wrap_coord(pend_x + f + gap);
					pend_w = second;
					split_w = 0;
				end else begin
					f = split_span(pend_h, gap, second);
					push_tile(pend_handle, pend_x, pend_y, pend_w, f, 1'b0);
					pend_y = wrap_coord(pend_y + f + gap);
					pend_h = second;
					split_w = 1;
				end
				pend_handle = e.handle;
			end
			if (e.last) begin
				if (have_pend) begin
					push_tile(pend_handle, pend_x, pend_y, pend_w, pend_h, 1'b1);
				end else begin
					empty_tile = '0;
					empty_tile.pass_done = 1'b1;
					empty_tile.no_window = 1'b1;
					expected_tiles.insert(expected_tiles.size(), empty_tile);
				end
				have_pend = 0;
				split_w = 0;
			end
		endfunction

		function void check_tile(dwr_result_t got);
			dwr_result_t exp_t;
			if (expected_tiles.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected tile beat: handle=%0d x=%0d y=%0d w=%0d h=%0d done=%0b none=%0b",
						got.window_handle, got.area_x, got.area_y, got.area_width,
						got.area_height, got.pass_done, got.no_window);
				return;
			end
			exp_t = expected_tiles.pop_front();
			if (got.window_handle !== exp_t.window_handle || got.area_x !== exp_t.area_x ||
					got.area_y !== exp_t.area_y || got.area_width !== exp_t.area_width ||
					got.area_height !== exp_t.area_height || got.pass_done !== exp_t.pass_done ||
					got.no_window !== exp_t.no_window) begin
				errors++;
				if (errors <= 10) begin
					$display("tile mismatch, expected: handle=%0d x=%0d y=%0d w=%0d h=%0d done=%0b none=%0b",
						exp_t.window_handle, exp_t.area_x, exp_t.area_y, exp_t.area_width,
						exp_t.area_height, exp_t.pass_done, exp_t.no_window);
					$display("tile mismatch, actual:   handle=%0d x=%0d y=%0d w=%0d h=%0d done=%0b none=%0b",
						got.window_handle, got.area_x, got.area_y, got.area_width,
						got.area_height, got.pass_done, got.no_window);
				end
			end
		endfunction

		function int outstanding();
			return expected_tiles.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wen = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
	logic                      s_axis_tlast = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tuser;

	tile_scoreboard sb = new();
	int  cycle_count = 0;
	int  hold_request = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	bit  tx_calm = 0;
	bit  rx_calm = 0;

	dwindle_rectangle_split DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("dwindle_rectangle_split test failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int pick_span();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return $urandom_range(0, 4);
			3: return int'($urandom_range(0, 65535)) - 32768;
			default: return $urandom_range(100, 4000);
		endcase
	endfunction

	// tile beat sink, random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = 1'b1;
			if (!rx_calm && $urandom_range(0, 99) < 20)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		dwr_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.window_handle = m_axis_tdata[X_LSB-1:0];
			got.area_x = m_axis_tdata[Y_LSB-1:X_LSB];
			got.area_y = m_axis_tdata[W_LSB-1:Y_LSB];
			got.area_width = m_axis_tdata[H_LSB-1:W_LSB];
			got.area_height = m_axis_tdata[H_LSB+SPAN_BITS-1:H_LSB];
			got.pass_done = m_axis_tlast;
			got.no_window = m_axis_tuser;
			sb.check_tile(got);
		end
	end

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic load_config(int ox, int oy, int uw, int uh, int gap, int scr, int ws);
		write_reg(REG_ORIGIN_X, CFG_DATA_BITS'(ox));
		write_reg(REG_ORIGIN_Y, CFG_DATA_BITS'(oy));
		write_reg(REG_USABLE_WIDTH, CFG_DATA_BITS'(uw));
		write_reg(REG_USABLE_HEIGHT, CFG_DATA_BITS'(uh));
		write_reg(REG_GAP_SIZE, CFG_DATA_BITS'(gap));
		write_reg(REG_SCREEN_SEL, CFG_DATA_BITS'(scr));
		write_reg(REG_WORKSPACE_SEL, CFG_DATA_BITS'(ws));
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic send_entry(logic [HANDLE_BITS-1:0] h, logic [SCREEN_BITS-1:0] s,
			logic [WS_BITS-1:0] w, logic l);
		entry_t e;
		int gap;
		e.handle = h;
		e.screen = s;
		e.workspace = w;
		e.last = l;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = IN_DATA_BITS'({w, s, h});
		s_axis_tlast = l;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_entry(e);
		gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering, let every tile drain, then give the engine time to go idle
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent, len, ox, oy, uw, uh, gp, scr, ws;
		logic [SCREEN_BITS-1:0] es;
		logic [WS_BITS-1:0] ew;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pass, single window, splits with ignored entry, foreign last entry
		load_config(10, 20, 1000, 600, 4, 3, 7);
		send_entry(8'd0, 4'd0, 5'd0, 1'b1);
		send_entry(8'd255, 4'd3, 5'd7, 1'b1);
		send_entry(8'd1, 4'd3, 5'd7, 1'b0);
		send_entry(8'd2, 4'd3, 5'd7, 1'b0);
		send_entry(8'h80, 4'd15, 5'd31, 1'b0);
		send_entry(8'd3, 4'd3, 5'd7, 1'b0);
		send_entry(8'd4, 4'd3, 5'd7, 1'b0);
		send_entry(8'd5, 4'd3, 5'd7, 1'b1);
		send_entry(8'd9, 4'd3, 5'd7, 1'b0);
		send_entry(8'd10, 4'd3, 5'd7, 1'b0);
		send_entry(8'd11, 4'd15, 5'd31, 1'b1);
		settle();

		// negative usable size, huge gap, wrapping coordinates
		load_config(32767, -32768, -32768, 0, 1023, 15, 31);
		send_entry(8'd0, 4'd15, 5'd31, 1'b0);
		send_entry(8'd1, 4'd15, 5'd31, 1'b0);
		send_entry(8'd2, 4'd15, 5'd31, 1'b0);
		send_entry(8'd3, 4'd15, 5'd31, 1'b1);
		settle();

		load_config(-32768, 32767, 32767, 32767, 0, 0, 0);
		send_entry(8'd170, 4'd0, 5'd0, 1'b0);
		send_entry(8'd85, 4'd0, 5'd0, 1'b0);
		send_entry(8'd204, 4'd0, 5'd0, 1'b0);
		send_entry(8'd51, 4'd0, 5'd0, 1'b1);
		settle();

		// unit spans cannot be split any further
		load_config(0, 0, 1, 1, 0, 0, 0);
		send_entry(8'd7, 4'd0, 5'd0, 1'b0);
		send_entry(8'd8, 4'd0, 5'd0, 1'b0);
		send_entry(8'd9, 4'd0, 5'd0, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			ox = pick_coord();
			oy = pick_coord();
			uw = pick_span();
			uh = pick_span();
			case ($urandom_range(0, 7))
				0: gp = 0;
				1: gp = 1023;
				2: gp = $urandom_range(0, 1023);
				default: gp = $urandom_range(0, 24);
			endcase
			if (p == 0) begin
				scr = 15;
				ws = 31;
			end else if (p == 1) begin
				scr = 0;
				ws = 0;
			end else begin
				scr = $urandom_range(0, 15);
				ws = $urandom_range(0, 31);
			end
			load_config(ox, oy, uw, uh, gp, scr, ws);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (p == 4 || p == 15) begin
				hold_request = 400;
				tx_calm = 1;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 15) begin
					send_entry(HANDLE_BITS'($urandom), SCREEN_BITS'($urandom),
						WS_BITS'($urandom), 1'($urandom));
					sent++;
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 99) < 85) begin
							es = SCREEN_BITS'(scr);
							ew = WS_BITS'(ws);
						end else begin
							es = SCREEN_BITS'($urandom);
							ew = WS_BITS'($urandom);
						end
						send_entry(HANDLE_BITS'($urandom), es, ew, k == len - 1);
						sent++;
					end
				end
			end
		end

		settle();
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("dwindle_rectangle_split test passed");
		else
			$display("dwindle_rectangle_split test failed");
		$finish;
	end

endmodule
